FILE: rtl/ace_pkg.sv
// Shared types, codes and constants for the ARP cache engine.
// Used by ace_cell, ace_ctrl and arp_cache_engine; depends on nothing.
package ace_pkg;

  localparam int TableEntries = 8;
  localparam int MacBytes     = 6;
  localparam int IdxW         = (TableEntries > 1) ? $clog2(TableEntries) : 1;

  typedef enum logic [1:0] {
    ENT_EMPTY   = 2'd0,
    ENT_PENDING = 2'd1,
    ENT_STABLE  = 2'd2,
    ENT_UNUSED  = 2'd3
  } ent_state_t;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_LEARN   = 2'd1,
    OP_ARP     = 2'd2,
    OP_RESOLVE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    STS_DONE     = 3'd0,
    STS_RESOLVED = 3'd1,
    STS_REQUEST  = 3'd2,
    STS_NOROUTE  = 3'd3,
    STS_FULL     = 3'd4,
    STS_REPLY    = 3'd5,
    STS_IGNORED  = 3'd6
  } status_t;

  localparam logic [15:0] ArpRequest = 16'd1;
  localparam logic [15:0] ArpReply   = 16'd2;

  typedef enum logic [2:0] {
    REG_OWN_IP      = 3'd0,
    REG_SUBNET_MASK = 3'd1,
    REG_GATEWAY_IP  = 3'd2,
    REG_ALWAYS_INS  = 3'd3,
    REG_STABLE_MAX  = 3'd4,
    REG_PENDING_MAX = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_DECIDE,
    FSM_WRITE,
    FSM_DONE
  } fsm_t;

  typedef enum logic [1:0] {
    WR_TICK,
    WR_MATCH,
    WR_INSERT,
    WR_PEND
  } wr_kind_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    ent_state_t  st;
    logic [7:0]  age;
  } entry_t;

  typedef struct packed {
    logic [31:0] own_ip;
    logic [31:0] subnet_mask;
    logic [31:0] gateway_ip;
    logic        always_insert;
    logic [7:0]  stable_max_age;
    logic [7:0]  pending_max_age;
  } cfg_t;

  // Bytes of a MAC address that an update may write; byte 0 is the top byte.
  function automatic logic [47:0] mac_mask_f();
    logic [47:0] m;
    m = '0;
    for (int k = 0; k < 6; k++) begin
      if (k < MacBytes) begin
        m[40-8*k +: 8] = 8'hff;
      end
    end
    return m;
  endfunction

  localparam logic [47:0] MacMask = mac_mask_f();

endpackage

FILE: rtl/arp_cache_engine.sv
// ARP cache top level: configuration registers, the row of entry cells and
// the sequencer. Depends on ace_pkg, ace_cell and ace_ctrl.
// A tick runs one write pass; learn, ARP update and resolve run a scan pass,
// a decision and at most one write pass; a reply updating two pairs does so twice.
// One word at a time; each scan or write pass rotates the whole row once.
// Reset (synchronous, rst high) empties the table and loads register defaults.
module arp_cache_engine
  import ace_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // arp_opcode[15:0], first_ip[47:16], first_mac[95:48],
  // second_ip[127:96], second_mac[175:128]
  input  logic [175:0] s_tdata,
  // op[1:0]
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // result_mac[47:0], result_ip[79:48]
  output logic [79:0]  m_tdata,
  // status[2:0]
  output logic [2:0]   m_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  cfg_t     cfg;
  reg_idx_t widx;
  entry_t   row [TableEntries];
  entry_t   tail, head;
  logic     shift;

  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[4:2]);

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{own_ip: '0, subnet_mask: '0, gateway_ip: '0, always_insert: 1'b0,
               stable_max_age: 8'd120, pending_max_age: 8'd2};
    end else if (psel && penable && pwrite) begin
      case (widx)
        REG_OWN_IP:      cfg.own_ip          <= pwdata;
        REG_SUBNET_MASK: cfg.subnet_mask     <= pwdata;
        REG_GATEWAY_IP:  cfg.gateway_ip      <= pwdata;
        REG_ALWAYS_INS:  cfg.always_insert   <= pwdata[0];
        REG_STABLE_MAX:  cfg.stable_max_age  <= pwdata[7:0];
        REG_PENDING_MAX: cfg.pending_max_age <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // Register reads.
  always_comb begin
    case (widx)
      REG_OWN_IP:      prdata = cfg.own_ip;
      REG_SUBNET_MASK: prdata = cfg.subnet_mask;
      REG_GATEWAY_IP:  prdata = cfg.gateway_ip;
      REG_ALWAYS_INS:  prdata = {31'd0, cfg.always_insert};
      REG_STABLE_MAX:  prdata = {24'd0, cfg.stable_max_age};
      REG_PENDING_MAX: prdata = {24'd0, cfg.pending_max_age};
      default:         prdata = '0;
    endcase
  end

  // Row of cells: each takes its upper neighbor, the last takes the tail word.
  for (genvar k = 0; k < TableEntries; k++) begin : g_cell
    entry_t din;
    if (k == TableEntries - 1) begin : g_last
      assign din = tail;
    end else begin : g_mid
      assign din = row[k+1];
    end
    ace_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .shift(shift),
      .din  (din),
      .dout (row[k])
    );
  end

  assign head = row[0];

  ace_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .head    (head),
    .tail    (tail),
    .shift   (shift)
  );

endmodule

FILE: rtl/ace_cell.sv
// One table entry of the ARP cache; part of the circulating row of cells.
// Depends on ace_pkg for the entry type.
module ace_cell
  import ace_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   shift,
  input  entry_t din,
  output entry_t dout
);

  entry_t entry;

  // Take the neighbor's entry whenever the row rotates.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '{ip: '0, mac: '0, st: ENT_EMPTY, age: '0};
    end else if (shift) begin
      entry <= din;
    end
  end

  assign dout = entry;

endmodule

FILE: rtl/ace_ctrl.sv
// Sequencer of the ARP cache: scans the rotating row of cells, decides and
// writes back as entries pass the head. Depends on ace_pkg.
module ace_ctrl
  import ace_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [175:0]  s_tdata,
  input  logic [1:0]    s_tuser,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [79:0]   m_tdata,
  output logic [2:0]    m_tuser,
  input  entry_t        head,
  output entry_t        tail,
  output logic          shift
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(TableEntries - 1);

  typedef enum logic [1:0] {
    PATH_DONE,
    PATH_SCAN,
    PATH_TICK
  } path_t;

  fsm_t          state, state_next;
  logic [IdxW-1:0] cnt;

  // Current job and the item's second job.
  logic [31:0] cur_ip;
  logic [47:0] cur_mac;
  logic        cur_ins, cur_res;
  logic        second;
  logic [31:0] ip2;
  logic [47:0] mac2;
  logic        keep;

  // Result being built.
  status_t     res_status;
  logic [47:0] res_mac;
  logic [31:0] res_ip;

  // Scan accumulators.
  logic            m_found, s_found, p_found, e_found, b_found;
  logic [IdxW-1:0] m_idx, e_idx, b_idx;
  logic [7:0]      b_age;
  logic [47:0]     s_mac;

  // Write pass.
  wr_kind_t        wkind;
  logic [IdxW-1:0] wtgt;

  // Decoded input word.
  logic [15:0] in_opc;
  logic [31:0] in_ip1, in_ip2;
  logic [47:0] in_mac1, in_mac2;
  op_t         in_op;

  assign in_opc  = s_tdata[15:0];
  assign in_ip1  = s_tdata[47:16];
  assign in_mac1 = s_tdata[95:48];
  assign in_ip2  = s_tdata[127:96];
  assign in_mac2 = s_tdata[175:128];
  assign in_op   = op_t'(s_tuser);

  // Classify an accepted word and preset its job and result.
  path_t       a_path;
  status_t     a_status;
  logic [47:0] a_mac;
  logic [31:0] a_ip, a_cip;
  logic        a_ins, a_res, a_keep, a_second;
  logic [31:0] host;
  logic        bcast, mcast, onsub1;

  always_comb begin
    host     = ~cfg.subnet_mask;
    bcast    = (in_ip1 == '0) || (in_ip1 == '1) ||
               ((host != '0) && ((in_ip1 & host) == host));
    mcast    = (in_ip1[31:28] == 4'he);
    onsub1   = ((in_ip1 & cfg.subnet_mask) == (cfg.own_ip & cfg.subnet_mask));
    a_path   = PATH_DONE;
    a_status = STS_DONE;
    a_mac    = '0;
    a_ip     = '0;
    a_cip    = in_ip1;
    a_ins    = 1'b0;
    a_res    = 1'b0;
    a_keep   = 1'b0;
    a_second = 1'b0;
    case (in_op)
      OP_TICK: begin
        a_path = PATH_TICK;
      end
      OP_LEARN: begin
        if (onsub1) begin
          a_path = PATH_SCAN;
          a_ins  = 1'b1;
        end else begin
          a_status = STS_IGNORED;
        end
      end
      OP_ARP: begin
        if (in_opc == ArpRequest) begin
          if (cfg.own_ip == '0) begin
            a_status = STS_IGNORED;
          end else begin
            a_path = PATH_SCAN;
            if (in_ip2 == cfg.own_ip) begin
              a_status = STS_REPLY;
              a_mac    = in_mac1;
              a_ip     = in_ip1;
              a_keep   = 1'b1;
            end
          end
        end else if (in_opc == ArpReply) begin
          a_path = PATH_SCAN;
          if (in_ip2 == cfg.own_ip) begin
            a_ins = 1'b1;
          end else begin
            a_second = 1'b1;
          end
        end else begin
          a_status = STS_IGNORED;
        end
      end
      default: begin
        if (bcast) begin
          a_status = STS_RESOLVED;
          a_mac    = '1;
        end else if (mcast) begin
          a_status = STS_RESOLVED;
          a_mac    = {24'h01005e, 1'b0, in_ip1[22:0]};
        end else if (!onsub1 && (cfg.gateway_ip == '0)) begin
          a_status = STS_NOROUTE;
        end else begin
          a_path = PATH_SCAN;
          a_res  = 1'b1;
          if (!onsub1) begin
            a_cip = cfg.gateway_ip;
          end
        end
      end
    endcase
  end

  // Fold the head entry into the scan accumulators.
  logic            n_m_found, n_s_found, n_p_found, n_e_found, n_b_found;
  logic [IdxW-1:0] n_m_idx, n_e_idx, n_b_idx;
  logic [7:0]      n_b_age;
  logic [47:0]     n_s_mac;
  logic            ipm;

  always_comb begin
    if (cnt == '0) begin
      n_m_found = 1'b0; n_s_found = 1'b0; n_p_found = 1'b0;
      n_e_found = 1'b0; n_b_found = 1'b0;
      n_m_idx = '0; n_e_idx = '0; n_b_idx = '0; n_b_age = '0; n_s_mac = '0;
    end else begin
      n_m_found = m_found; n_s_found = s_found; n_p_found = p_found;
      n_e_found = e_found; n_b_found = b_found;
      n_m_idx = m_idx; n_e_idx = e_idx; n_b_idx = b_idx; n_b_age = b_age;
      n_s_mac = s_mac;
    end
    ipm = (head.ip == cur_ip);
    if (!n_m_found && ipm && (head.st == ENT_PENDING || head.st == ENT_STABLE)) begin
      n_m_found = 1'b1;
      n_m_idx   = cnt;
    end
    if (!n_s_found && ipm && head.st == ENT_STABLE) begin
      n_s_found = 1'b1;
      n_s_mac   = head.mac;
    end
    if (ipm && head.st == ENT_PENDING) begin
      n_p_found = 1'b1;
    end
    if (!n_e_found && head.st == ENT_EMPTY) begin
      n_e_found = 1'b1;
      n_e_idx   = cnt;
    end
    if (head.st == ENT_STABLE && (!n_b_found || head.age >= n_b_age)) begin
      n_b_found = 1'b1;
      n_b_idx   = cnt;
      n_b_age   = head.age;
    end
  end

  // Decision after a scan: write kind, target and the result it gives.
  logic            v_found;
  logic [IdxW-1:0] v_idx;
  logic            d_write, d_full;
  wr_kind_t        d_kind;
  logic [IdxW-1:0] d_tgt;

  always_comb begin
    v_found = e_found || b_found;
    v_idx   = e_found ? e_idx : b_idx;
    d_write = 1'b0;
    d_full  = 1'b0;
    d_kind  = WR_MATCH;
    d_tgt   = v_idx;
    if (cur_res) begin
      if (!s_found && !p_found) begin
        if (v_found) begin
          d_write = 1'b1;
          d_kind  = WR_PEND;
        end else begin
          d_full = 1'b1;
        end
      end
    end else if (cur_ip != '0) begin
      if (m_found) begin
        d_write = 1'b1;
        d_tgt   = m_idx;
      end else if (cur_ins || cfg.always_insert) begin
        if (v_found) begin
          d_write = 1'b1;
          d_kind  = WR_INSERT;
        end else begin
          d_full = 1'b1;
        end
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      FSM_IDLE: begin
        if (s_tvalid) begin
          case (a_path)
            PATH_SCAN: state_next = FSM_SCAN;
            PATH_TICK: state_next = FSM_WRITE;
            default:   state_next = FSM_DONE;
          endcase
        end
      end
      FSM_SCAN: begin
        if (cnt == LastIdx) begin
          state_next = FSM_DECIDE;
        end
      end
      FSM_DECIDE: begin
        if (d_write) begin
          state_next = FSM_WRITE;
        end else if (second) begin
          state_next = FSM_SCAN;
        end else begin
          state_next = FSM_DONE;
        end
      end
      FSM_WRITE: begin
        if (cnt == LastIdx) begin
          state_next = second ? FSM_SCAN : FSM_DONE;
        end
      end
      FSM_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = FSM_IDLE;
        end
      end
      default: state_next = FSM_IDLE;
    endcase
  end

  // Outputs: handshake, row rotation and the entry written back at the tail.
  logic [7:0] age_inc;

  always_comb begin
    s_tready = (state == FSM_IDLE);
    shift    = (state == FSM_SCAN) || (state == FSM_WRITE);
    age_inc  = head.age + 8'd1;
    tail     = head;
    if (state == FSM_WRITE) begin
      case (wkind)
        WR_TICK: begin
          tail.age = age_inc;
          if (head.st == ENT_STABLE && age_inc >= cfg.stable_max_age) begin
            tail.st = ENT_EMPTY;
          end else if (head.st == ENT_PENDING && age_inc >= cfg.pending_max_age) begin
            tail.st = ENT_EMPTY;
          end
        end
        WR_MATCH: begin
          if (cnt == wtgt) begin
            tail.st  = ENT_STABLE;
            tail.mac = (head.mac & ~MacMask) | (cur_mac & MacMask);
            tail.age = '0;
          end
        end
        WR_INSERT: begin
          if (cnt == wtgt) begin
            tail.ip  = cur_ip;
            tail.st  = ENT_STABLE;
            tail.mac = (head.mac & ~MacMask) | (cur_mac & MacMask);
            tail.age = '0;
          end
        end
        default: begin
          if (cnt == wtgt) begin
            tail.ip  = cur_ip;
            tail.st  = ENT_PENDING;
            tail.age = '0;
          end
        end
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= FSM_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (shift) begin
        cnt <= (cnt == LastIdx) ? '0 : cnt + 1'b1;
      end
      if (state == FSM_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Job, scan and result registers.
  always_ff @(posedge clk) begin
    case (state)
      FSM_IDLE: begin
        if (s_tvalid) begin
          cur_ip     <= a_cip;
          cur_mac    <= in_mac1;
          cur_ins    <= a_ins;
          cur_res    <= a_res;
          second     <= a_second;
          ip2        <= in_ip2;
          mac2       <= in_mac2;
          keep       <= a_keep;
          res_status <= a_status;
          res_mac    <= a_mac;
          res_ip     <= a_ip;
          wkind      <= WR_TICK;
        end
      end
      FSM_SCAN: begin
        m_found <= n_m_found; s_found <= n_s_found; p_found <= n_p_found;
        e_found <= n_e_found; b_found <= n_b_found;
        m_idx <= n_m_idx; e_idx <= n_e_idx; b_idx <= n_b_idx;
        b_age <= n_b_age; s_mac <= n_s_mac;
      end
      FSM_DECIDE: begin
        wkind <= d_kind;
        wtgt  <= d_tgt;
        if (cur_res) begin
          if (s_found) begin
            res_status <= STS_RESOLVED;
            res_mac    <= s_mac;
          end else if (d_full) begin
            res_status <= STS_FULL;
          end else begin
            res_status <= STS_REQUEST;
            res_ip     <= cur_ip;
          end
        end else if (d_full && !keep) begin
          res_status <= STS_FULL;
        end
        if (!d_write && second) begin
          cur_ip  <= ip2;
          cur_mac <= mac2;
          cur_ins <= 1'b0;
          second  <= 1'b0;
        end
      end
      FSM_WRITE: begin
        if (cnt == LastIdx && second) begin
          cur_ip  <= ip2;
          cur_mac <= mac2;
          cur_ins <= 1'b0;
          second  <= 1'b0;
        end
      end
      FSM_DONE: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= {res_ip, res_mac};
          m_tuser <= res_status;
        end
      end
      default: begin
      end
    endcase
  end

  // The row is aligned with logical index zero whenever no pass runs.
  a_aligned: assert property (@(posedge clk) disable iff (rst)
    (state == FSM_IDLE || state == FSM_DONE || state == FSM_DECIDE) |-> cnt == '0)
    else $error("row not aligned outside a pass");

  // An accepted word always leaves the idle state.
  a_leave: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> state != FSM_IDLE)
    else $error("accepted word did not start work");

  // A result word appears only after the done state.
  a_result: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == FSM_DONE))
    else $error("result raised outside the done state");

endmodule
